// ===== rtl/core/gsa_pkg.sv =====
// ----------------------------------------------------------------------------
// gsa_pkg: shared types and helpers of the global sequence aligner
// Score type, saturation, direction codes, register indexes and the cell link.
// ----------------------------------------------------------------------------
package gsa_pkg;

    localparam int MAX_LEN = 32;
    localparam int IDX_W   = $clog2(MAX_LEN);
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int SCORE_W = 14;
    localparam int EXT_W   = SCORE_W + 16;

    typedef logic signed [SCORE_W-1:0] score_t;
    typedef logic signed [EXT_W-1:0]   ext_t;
    typedef logic signed [7:0]         weight_t;

    typedef enum logic [1:0] {
        DIR_DIAG = 2'd1,
        DIR_LEFT = 2'd2,
        DIR_UP   = 2'd3
    } dir_t;

    typedef enum logic [1:0] {
        REG_GAP      = 2'd0,
        REG_MATCH    = 2'd1,
        REG_MISMATCH = 2'd2
    } reg_idx_t;

    // Data handed from one cell to the next
    typedef struct packed {
        logic             valid;
        logic [7:0]       sym;
        logic [IDX_W-1:0] row;
        score_t           left;
        score_t           diag;
    } link_t;

    localparam ext_t SCORE_HI = ext_t'((64'sd1 <<< (SCORE_W - 1)) - 64'sd1);
    localparam ext_t SCORE_LO = ext_t'(-(64'sd1 <<< (SCORE_W - 1)));

    // Clamp a wide value to the score range
    function automatic score_t sat_ext(input ext_t v);
        score_t r;
        if (v > SCORE_HI) begin
            r = SCORE_HI[SCORE_W-1:0];
        end else if (v < SCORE_LO) begin
            r = SCORE_LO[SCORE_W-1:0];
        end else begin
            r = v[SCORE_W-1:0];
        end
        return r;
    endfunction

    // Saturating add of a score and a weight
    function automatic score_t sat_add(input score_t a, input weight_t b);
        ext_t s;
        s = ext_t'(a) + ext_t'(b);
        return sat_ext(s);
    endfunction

endpackage

// ===== rtl/core/gsa_cell.sv =====
// ----------------------------------------------------------------------------
// gsa_cell: one column cell of the systolic score grid
// Holds one column symbol and its running score, stores its directions.
// ----------------------------------------------------------------------------
module gsa_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      init,
    input  logic [gsa_pkg::LEN_W-1:0] cell_pos,
    input  gsa_pkg::weight_t          gap_w,
    input  gsa_pkg::weight_t          match_w,
    input  gsa_pkg::weight_t          mismatch_w,
    input  logic                      col_we,
    input  logic [7:0]                col_sym_in,
    input  gsa_pkg::link_t            link_in,
    output gsa_pkg::link_t            link_out,
    input  logic [gsa_pkg::IDX_W-1:0] rd_addr,
    output logic [1:0]                dir_q,
    output logic [7:0]                col_sym,
    output gsa_pkg::score_t           score
);

    logic [7:0]      col_sym_reg;
    gsa_pkg::score_t up_reg;
    gsa_pkg::link_t  link_reg;
    logic [1:0]      dir_q_reg;
    logic [1:0]      dir_mem [gsa_pkg::MAX_LEN];

    gsa_pkg::score_t diag_s, left_s, up_s, best;
    gsa_pkg::dir_t   dir_sel;
    gsa_pkg::ext_t   init_prod;

    // Pick the best of the three candidates, diagonal first
    always_comb begin
        diag_s = gsa_pkg::sat_add(link_in.diag,
                     (link_in.sym == col_sym_reg) ? match_w : mismatch_w);
        left_s = gsa_pkg::sat_add(link_in.left, gap_w);
        up_s   = gsa_pkg::sat_add(up_reg, gap_w);
        if (diag_s >= left_s && diag_s >= up_s) begin
            best    = diag_s;
            dir_sel = gsa_pkg::DIR_DIAG;
        end else if (left_s >= up_s) begin
            best    = left_s;
            dir_sel = gsa_pkg::DIR_LEFT;
        end else begin
            best    = up_s;
            dir_sel = gsa_pkg::DIR_UP;
        end
        init_prod = gsa_pkg::ext_t'($signed({1'b0, cell_pos})) * gsa_pkg::ext_t'(gap_w);
    end

    // Score, symbol and link payload; request valid along the chain
    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_sym_reg <= col_sym_in;
        end
        if (init) begin
            up_reg <= gsa_pkg::sat_ext(init_prod);
        end else if (link_in.valid) begin
            up_reg <= best;
        end
        if (!aresetn || init) begin
            link_reg.valid <= 1'b0;
        end else begin
            link_reg.valid <= link_in.valid;
        end
        link_reg.sym  <= link_in.sym;
        link_reg.row  <= link_in.row;
        link_reg.left <= best;
        link_reg.diag <= up_reg;
    end

    // Direction memory, one entry per row
    always_ff @(posedge aclk) begin
        if (link_in.valid) begin
            dir_mem[link_in.row] <= dir_sel;
        end
        dir_q_reg <= dir_mem[rd_addr];
    end

    assign link_out = link_reg;
    assign dir_q    = dir_q_reg;
    assign col_sym  = col_sym_reg;
    assign score    = up_reg;

endmodule

// ===== rtl/core/global_sequence_aligner_top.sv =====
// ----------------------------------------------------------------------------
// global_sequence_aligner_top: global alignment with linear gap score
// Loads two sequences, fills the grid in a cell chain, traces back, emits.
// ----------------------------------------------------------------------------
// Loading accepts one symbol per cycle. After the last second-sequence symbol
// the fill runs through the cell chain, the traceback steps through S_TB_RD
// and S_TB_USE for each column, and emission through S_EM_RD, S_EM_LOAD and
// S_EM_WAIT for each column, where it may stall on m_tready.
// Reset (aresetn low, synchronous) empties both sequences and restores the
// default scores; no request is taken until the current result run ends.
module global_sequence_aligner_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // symbol
    input  logic        s_tuser,   // operation
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // top_symbol, bottom_symbol, total_score, overflow
    output logic [1:0]  m_tuser,   // top_gap, bottom_gap
    output logic        m_tlast
);

    localparam int N     = gsa_pkg::MAX_LEN;
    localparam int IW    = gsa_pkg::IDX_W;
    localparam int LW    = gsa_pkg::LEN_W;
    localparam int STK_W = $clog2(2 * N);
    localparam int CNT_W = STK_W + 1;
    localparam int FW    = LW + 2;

    typedef enum logic [2:0] {
        S_LOAD, S_INIT, S_FILL, S_TB_RD, S_TB_USE, S_EM_RD, S_EM_LOAD, S_EM_WAIT
    } state_t;

    typedef struct packed {
        logic [7:0] top;
        logic       top_gap;
        logic [7:0] bot;
        logic       bot_gap;
    } column_t;

    state_t            state_reg;
    gsa_pkg::weight_t  gap_reg, match_reg, mismatch_reg;
    logic [LW-1:0]     row_len_reg, col_len_reg;
    logic              ovf_reg;
    logic [7:0]        row_mem [N];
    logic [7:0]        row_q_reg;
    logic [IW-1:0]     row_addr;
    logic [LW-1:0]     feed_cnt_reg;
    logic              feed_pend_reg;
    logic [IW-1:0]     feed_row_reg;
    gsa_pkg::score_t   edge_reg, edge_next;
    logic [FW-1:0]     fill_cnt_reg;
    logic [LW-1:0]     i_reg, j_reg, i_next, j_next;
    logic [CNT_W-1:0]  n_reg;
    logic [STK_W-1:0]  ptr_reg;
    column_t           stack_mem [2 * N];
    column_t           stack_q_reg, col_new;
    gsa_pkg::score_t   total_reg;
    logic              m_valid_reg, m_last_reg;
    logic [31:0]       m_data_reg;
    logic [1:0]        m_user_reg;

    gsa_pkg::link_t    links [N + 1];
    logic [1:0]        dir_q [N];
    logic [7:0]        col_sym [N];
    gsa_pkg::score_t   cell_score [N];
    logic              col_we [N];
    logic              accept;
    logic [IW-1:0]     j_idx, c_idx;
    logic [1:0]        dir_use;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_LOAD);
    assign j_idx    = IW'(j_reg - LW'(1));
    assign c_idx    = IW'(col_len_reg - LW'(1));
    assign row_addr = (state_reg == S_FILL) ? feed_cnt_reg[IW-1:0] : IW'(i_reg - LW'(1));
    assign edge_next = gsa_pkg::sat_add(edge_reg, gap_reg);

    // Feed the first cell from the row sequence and the left grid edge
    assign links[0] = {feed_pend_reg, row_q_reg, feed_row_reg, edge_next, edge_reg};

    // Cell chain, one cell per column symbol
    for (genvar k = 0; k < N; k++) begin : g_cell
        assign col_we[k] = accept && s_tuser && (col_len_reg == LW'(k));
        gsa_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .init       (state_reg == S_INIT),
            .cell_pos   (LW'(k + 1)),
            .gap_w      (gap_reg),
            .match_w    (match_reg),
            .mismatch_w (mismatch_reg),
            .col_we     (col_we[k]),
            .col_sym_in (s_tdata),
            .link_in    (links[k]),
            .link_out   (links[k + 1]),
            .rd_addr    (row_addr),
            .dir_q      (dir_q[k]),
            .col_sym    (col_sym[k]),
            .score      (cell_score[k])
        );
    end

    // Build the traceback column, edges force a straight walk
    always_comb begin
        if (j_reg == '0) begin
            dir_use = gsa_pkg::DIR_UP;
        end else if (i_reg == '0) begin
            dir_use = gsa_pkg::DIR_LEFT;
        end else begin
            dir_use = dir_q[j_idx];
        end
        col_new = '0;
        i_next  = i_reg;
        j_next  = j_reg;
        unique case (dir_use)
            gsa_pkg::DIR_DIAG: begin
                col_new.top = row_q_reg;
                col_new.bot = col_sym[j_idx];
                i_next      = i_reg - LW'(1);
                j_next      = j_reg - LW'(1);
            end
            gsa_pkg::DIR_LEFT: begin
                col_new.top_gap = 1'b1;
                col_new.bot     = col_sym[j_idx];
                j_next          = j_reg - LW'(1);
            end
            default: begin
                col_new.top     = row_q_reg;
                col_new.bot_gap = 1'b1;
                i_next          = i_reg - LW'(1);
            end
        endcase
    end

    // Row symbol and column stack memories
    always_ff @(posedge aclk) begin
        if (accept && !s_tuser && row_len_reg < LW'(N)) begin
            row_mem[row_len_reg[IW-1:0]] <= s_tdata;
        end
        row_q_reg <= row_mem[row_addr];
        if (state_reg == S_TB_USE) begin
            stack_mem[n_reg[STK_W-1:0]] <= col_new;
        end
        stack_q_reg <= stack_mem[ptr_reg];
    end

    // Configuration writes and sequencer: load, init, fill, traceback, emit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            gap_reg       <= -8'sd2;
            match_reg     <= 8'sd1;
            mismatch_reg  <= -8'sd1;
            row_len_reg   <= '0;
            col_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            feed_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    gsa_pkg::REG_GAP:      gap_reg      <= cfg_data;
                    gsa_pkg::REG_MATCH:    match_reg    <= cfg_data;
                    gsa_pkg::REG_MISMATCH: mismatch_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_LOAD: begin
                    if (accept) begin
                        if (!s_tuser) begin
                            if (row_len_reg < LW'(N)) begin
                                row_len_reg <= row_len_reg + LW'(1);
                            end else begin
                                ovf_reg <= 1'b1;
                            end
                        end else begin
                            if (col_len_reg < LW'(N)) begin
                                col_len_reg <= col_len_reg + LW'(1);
                            end else begin
                                ovf_reg <= 1'b1;
                            end
                            if (s_tlast) begin
                                state_reg <= S_INIT;
                            end
                        end
                    end
                end
                S_INIT: begin
                    edge_reg      <= '0;
                    feed_cnt_reg  <= '0;
                    fill_cnt_reg  <= '0;
                    feed_pend_reg <= 1'b0;
                    state_reg     <= S_FILL;
                end
                S_FILL: begin
                    if (feed_pend_reg) begin
                        edge_reg <= edge_next;
                    end
                    if (feed_cnt_reg < row_len_reg) begin
                        feed_pend_reg <= 1'b1;
                        feed_row_reg  <= feed_cnt_reg[IW-1:0];
                        feed_cnt_reg  <= feed_cnt_reg + LW'(1);
                    end else begin
                        feed_pend_reg <= 1'b0;
                    end
                    fill_cnt_reg <= fill_cnt_reg + FW'(1);
                    if (fill_cnt_reg == FW'(row_len_reg) + FW'(col_len_reg) + FW'(2)) begin
                        total_reg <= cell_score[c_idx];
                        i_reg     <= row_len_reg;
                        j_reg     <= col_len_reg;
                        n_reg     <= '0;
                        state_reg <= S_TB_RD;
                    end
                end
                S_TB_RD: begin
                    state_reg <= S_TB_USE;
                end
                S_TB_USE: begin
                    i_reg <= i_next;
                    j_reg <= j_next;
                    n_reg <= n_reg + CNT_W'(1);
                    if (i_next == '0 && j_next == '0) begin
                        ptr_reg   <= n_reg[STK_W-1:0];
                        state_reg <= S_EM_RD;
                    end else begin
                        state_reg <= S_TB_RD;
                    end
                end
                S_EM_RD: begin
                    state_reg <= S_EM_LOAD;
                end
                S_EM_LOAD: begin
                    m_valid_reg <= 1'b1;
                    m_last_reg  <= (ptr_reg == '0);
                    m_user_reg  <= {stack_q_reg.bot_gap, stack_q_reg.top_gap};
                    m_data_reg  <= {1'b0, ovf_reg,
                                    (ptr_reg == '0) ? total_reg : gsa_pkg::score_t'(0),
                                    stack_q_reg.bot, stack_q_reg.top};
                    state_reg   <= S_EM_WAIT;
                end
                S_EM_WAIT: begin
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        if (ptr_reg == '0) begin
                            row_len_reg <= '0;
                            col_len_reg <= '0;
                            ovf_reg     <= 1'b0;
                            state_reg   <= S_LOAD;
                        end else begin
                            ptr_reg   <= ptr_reg - STK_W'(1);
                            state_reg <= S_EM_RD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_valid_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == S_EM_WAIT))
        else $error("result valid outside emission");
    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("request taken while result pending");
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TB_USE) |-> (n_reg < CNT_W'(2 * N)))
        else $error("traceback exceeds column stack");
    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (state_reg == S_LOAD))
        else $error("last column did not end the run");
`endif

endmodule
